// ===== rtl/ezr_pkg.sv =====
package ezr_pkg;

  localparam int IFRAC = 30;
  localparam int IW = 34;
  localparam int MAX_STEPS = 32;
  localparam logic signed [IW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [IW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [IW-1:0] GAIN_Q30 = 34'sd652032874;

  function automatic logic signed [IW-1:0] atan_entry(input int i);
    logic signed [IW-1:0] r;
    r = '0;
    unique case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: begin
        if (i <= IFRAC) r = IW'(64'sd1 <<< (IFRAC - i));
        else r = '0;
      end
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [IW-1:0] c;
    logic signed [IW-1:0] s;
  } sc_t;

endpackage

// ===== rtl/euler_zyx_to_rotation_matrix.sv =====
// Throughput: one transaction per cycle; a stall freezes the whole pipeline.
// Pipeline: fold, CORDIC_STEPS stages per lane (at most MAX_STEPS), two product stages.
// Reset: rst_ni asynchronous active low clears the valid pipeline only.
module euler_zyx_to_rotation_matrix #(
  parameter int ANGLE_WIDTH = 16,
  parameter int OUT_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [ANGLE_WIDTH-1:0] roll_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] pitch_angle_i,
  input  logic signed [ANGLE_WIDTH-1:0] yaw_angle_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [OUT_WIDTH-1:0]   m00_o,
  output logic signed [OUT_WIDTH-1:0]   m01_o,
  output logic signed [OUT_WIDTH-1:0]   m02_o,
  output logic signed [OUT_WIDTH-1:0]   m10_o,
  output logic signed [OUT_WIDTH-1:0]   m11_o,
  output logic signed [OUT_WIDTH-1:0]   m12_o,
  output logic signed [OUT_WIDTH-1:0]   m20_o,
  output logic signed [OUT_WIDTH-1:0]   m21_o,
  output logic signed [OUT_WIDTH-1:0]   m22_o
);
  import ezr_pkg::*;

  localparam int N = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
  localparam int LAT = N + 3;

  logic [LAT-1:0] v_q;
  logic           en;
  sc_t            sc_r, sc_p, sc_y;
  logic signed [OUT_WIDTH-1:0] m [9];

  assign en = !out_stall_i || !v_q[LAT-1];
  assign in_stall_o = !en;
  assign out_valid_o = v_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], in_valid_i};
    end
  end

  ezr_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk_i, .en_i(en), .angle_i(roll_angle_i), .sc_o(sc_r));
  ezr_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk_i, .en_i(en), .angle_i(pitch_angle_i), .sc_o(sc_p));
  ezr_cordic_lane #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
    .clk_i, .en_i(en), .angle_i(yaw_angle_i), .sc_o(sc_y));

  ezr_merge #(.OUT_WIDTH(OUT_WIDTH)) u_merge (
    .clk_i, .en_i(en), .r_i(sc_r), .p_i(sc_p), .y_i(sc_y), .m_o(m));

  assign m00_o = m[0];
  assign m01_o = m[1];
  assign m02_o = m[2];
  assign m10_o = m[3];
  assign m11_o = m[4];
  assign m12_o = m[5];
  assign m20_o = m[6];
  assign m21_o = m[7];
  assign m22_o = m[8];

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(m00_o) && $stable(m22_o))
    else $error("output changed under stall");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");
  a_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> m00_o <= (1 <<< (OUT_WIDTH-2)) && m00_o >= -(1 <<< (OUT_WIDTH-2)))
    else $error("entry out of range");
`endif
endmodule

// ===== rtl/ezr_cordic_lane.sv =====
module ezr_cordic_lane #(
  parameter int ANGLE_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [ANGLE_WIDTH-1:0] angle_i,
  output ezr_pkg::sc_t                  sc_o
);
  import ezr_pkg::*;

  localparam int N = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

  logic signed [IW-1:0] x_q [N+1];
  logic signed [IW-1:0] y_q [N+1];
  logic signed [IW-1:0] z_q [N+1];
  logic                 f_q [N+1];
  logic signed [IW-1:0] z0;

  always_comb begin
    z0 = IW'(angle_i) <<< (IFRAC + 3 - ANGLE_WIDTH);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= GAIN_Q30;
      y_q[0] <= '0;
      f_q[0] <= (z0 > HALF_PI_Q30) || (z0 < -HALF_PI_Q30);
      priority if (z0 > HALF_PI_Q30) z_q[0] <= z0 - PI_Q30;
      else if (z0 < -HALF_PI_Q30) z_q[0] <= z0 + PI_Q30;
      else z_q[0] <= z0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_q[i+1] <= f_q[i];
        if (!z_q[i][IW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_entry(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_entry(i);
        end
      end
    end
  end

  assign sc_o.c = f_q[N] ? -x_q[N] : x_q[N];
  assign sc_o.s = f_q[N] ? -y_q[N] : y_q[N];
endmodule

// ===== rtl/ezr_merge.sv =====
module ezr_merge #(
  parameter int OUT_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  ezr_pkg::sc_t                r_i,
  input  ezr_pkg::sc_t                p_i,
  input  ezr_pkg::sc_t                y_i,
  output logic signed [OUT_WIDTH-1:0] m_o [9]
);
  import ezr_pkg::*;

  localparam int SH = IFRAC + 2 - OUT_WIDTH;
  localparam logic signed [IW+1:0] ONE = (IW+2)'(64'sd1 <<< (OUT_WIDTH - 2));

  function automatic logic signed [IW-1:0] mulq(input logic signed [IW-1:0] a,
                                                input logic signed [IW-1:0] b);
    logic signed [2*IW-1:0] p;
    p = a * b + (2*IW)'(64'sd1 <<< (IFRAC - 1));
    return IW'(p >>> IFRAC);
  endfunction

  function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic signed [IW+1:0] v);
    logic signed [IW+1:0] r;
    r = v;
    if (SH > 0) r = (v + ((IW+2)'(1) <<< (SH - 1))) >>> SH;
    if (r > ONE) r = ONE;
    if (r < -ONE) r = -ONE;
    return OUT_WIDTH'(r);
  endfunction

  logic signed [IW-1:0] cysp_q, sysp_q, sycr_q, sysr_q, cycr_q, cysr_q;
  logic signed [IW-1:0] cycp_q, sycp_q, cpsr_q, cpcr_q, nsp_q;
  logic signed [IW-1:0] cr_q, sr_q;
  logic signed [IW+1:0] t_q [9];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cysp_q <= mulq(y_i.c, p_i.s);
      sysp_q <= mulq(y_i.s, p_i.s);
      sycr_q <= mulq(y_i.s, r_i.c);
      sysr_q <= mulq(y_i.s, r_i.s);
      cycr_q <= mulq(y_i.c, r_i.c);
      cysr_q <= mulq(y_i.c, r_i.s);
      cycp_q <= mulq(y_i.c, p_i.c);
      sycp_q <= mulq(y_i.s, p_i.c);
      cpsr_q <= mulq(p_i.c, r_i.s);
      cpcr_q <= mulq(p_i.c, r_i.c);
      nsp_q  <= -p_i.s;
      cr_q   <= r_i.c;
      sr_q   <= r_i.s;
      t_q[0] <= (IW+2)'(cycp_q);
      t_q[1] <= (IW+2)'(mulq(cysp_q, sr_q)) - (IW+2)'(sycr_q);
      t_q[2] <= (IW+2)'(mulq(cysp_q, cr_q)) + (IW+2)'(sysr_q);
      t_q[3] <= (IW+2)'(sycp_q);
      t_q[4] <= (IW+2)'(mulq(sysp_q, sr_q)) + (IW+2)'(cycr_q);
      t_q[5] <= (IW+2)'(mulq(sysp_q, cr_q)) - (IW+2)'(cysr_q);
      t_q[6] <= (IW+2)'(nsp_q);
      t_q[7] <= (IW+2)'(cpsr_q);
      t_q[8] <= (IW+2)'(cpcr_q);
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_out
    assign m_o[k] = to_out(t_q[k]);
  end
endmodule

// ===== tb/euler_zyx_to_rotation_matrix_test.sv =====
module euler_zyx_to_rotation_matrix_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW = 16;
  localparam int OW = 16;
  localparam int STEPS = 16;
  localparam int LATENCY = STEPS + 3;
  localparam int NUM_RANDOM = 1500;
  localparam longint CYCLE_LIMIT = 200000;
  localparam longint Q30_PI = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_GAIN = 64'sd652032874;
  localparam logic signed [OW-1:0] ONE = 16'sd16384;

  typedef struct {
    logic signed [OW-1:0] m [9];
  } matrix_t;

  typedef struct {
    logic signed [AW-1:0] roll;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] yaw;
    bit                   typed;
    matrix_t              want;
  } angle_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [AW-1:0] roll_angle_i = '0;
  logic signed [AW-1:0] pitch_angle_i = '0;
  logic signed [AW-1:0] yaw_angle_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [OW-1:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;

  euler_zyx_to_rotation_matrix #(
    .ANGLE_WIDTH(AW), .OUT_WIDTH(OW), .CORDIC_STEPS(STEPS)
  ) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .roll_angle_i, .pitch_angle_i, .yaw_angle_i,
    .out_valid_o, .out_stall_i,
    .m00_o, .m01_o, .m02_o, .m10_o, .m11_o, .m12_o, .m20_o, .m21_o, .m22_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  matrix_t pending_matrices [$];
  int errors = 0;
  longint cycles = 0;
  bit quiet_phase = 1'b0;
  string field_names [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

  function automatic longint arith_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q30(longint v);
    return (v + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic longint arctan_q30(int i);
    longint head [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                          33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return head[i];
    if (i <= 30) return 64'sd1 << (30 - i);
    return 0;
  endfunction

  task automatic cordic_sin_cos(input logic signed [AW-1:0] angle,
                                output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(angle) * (64'sd1 << (33 - AW));
    flip = 1'b0;
    x = Q30_GAIN;
    y = 0;
    if (z > Q30_HALF_PI) begin
      z -= Q30_PI;
      flip = 1'b1;
    end else if (z < -Q30_HALF_PI) begin
      z += Q30_PI;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = arith_shift(y, i);
      dy = arith_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q30(i);
      end else begin
        x += dx; y -= dy; z += arctan_q30(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic logic signed [OW-1:0] to_q14(longint v);
    longint r;
    r = (v + (64'sd1 << (31 - OW))) >>> (32 - OW);
    if (r > longint'(ONE)) r = ONE;
    if (r < -longint'(ONE)) r = -longint'(ONE);
    return OW'(r);
  endfunction

  task automatic rotation_matrix(input logic signed [AW-1:0] r, p, y, output matrix_t mx);
    longint cr, sr, cp, sp, cy, sy, cysp, sysp;
    cordic_sin_cos(r, cr, sr);
    cordic_sin_cos(p, cp, sp);
    cordic_sin_cos(y, cy, sy);
    cysp = round_q30(cy * sp);
    sysp = round_q30(sy * sp);
    mx.m[0] = to_q14(round_q30(cy * cp));
    mx.m[1] = to_q14(round_q30(cysp * sr) - round_q30(sy * cr));
    mx.m[2] = to_q14(round_q30(cysp * cr) + round_q30(sy * sr));
    mx.m[3] = to_q14(round_q30(sy * cp));
    mx.m[4] = to_q14(round_q30(sysp * sr) + round_q30(cy * cr));
    mx.m[5] = to_q14(round_q30(sysp * cr) - round_q30(cy * sr));
    mx.m[6] = to_q14(-sp);
    mx.m[7] = to_q14(round_q30(cp * sr));
    mx.m[8] = to_q14(round_q30(cp * cr));
  endtask

  function automatic bit idle_now();
    if (quiet_phase) return 1'b0;
    return $urandom_range(99) < 29;
  endfunction

  task automatic send_angles(input logic signed [AW-1:0] r, p, y);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    roll_angle_i <= r;
    pitch_angle_i <= p;
    yaw_angle_i <= y;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // identity matrix for zero angles
  function automatic matrix_t identity();
    matrix_t mx;
    foreach (mx.m[i]) mx.m[i] = (i % 4 == 0) ? ONE : '0;
    return mx;
  endfunction

  angle_row_t directed [] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, identity()},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, identity()},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, identity()},
    '{16'sh7fff, 16'sh8000, 16'sd0, 1'b0, identity()},
    '{16'sd0, 16'sh7fff, 16'sh8000, 1'b0, identity()},
    '{16'sd12868, 16'sd0, 16'sd0, 1'b0, identity()},
    '{16'sd0, 16'sd12868, 16'sd0, 1'b0, identity()},
    '{16'sd0, 16'sd0, 16'sd12868, 1'b0, identity()},
    '{16'sd12869, 16'sd12867, -16'sd12869, 1'b0, identity()},
    '{-16'sd12868, -16'sd12869, 16'sd12870, 1'b0, identity()},
    '{16'sd25736, 16'sd25736, 16'sd25736, 1'b0, identity()},
    '{-16'sd25736, 16'sd6434, -16'sd6434, 1'b0, identity()},
    '{16'sd1, -16'sd1, 16'sd1, 1'b0, identity()},
    '{16'sh5555, 16'shaaaa, 16'sh5555, 1'b0, identity()},
    '{16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0, identity()}
  };

  initial begin
    logic signed [AW-1:0] r, p, y;
    matrix_t mx;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      rotation_matrix(directed[i].roll, directed[i].pitch, directed[i].yaw, mx);
      if (directed[i].typed) mx = directed[i].want;
      pending_matrices.push_back(mx);
      send_angles(directed[i].roll, directed[i].pitch, directed[i].yaw);
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      quiet_phase = (n >= 600 && n < 800);
      r = AW'($urandom);
      p = AW'($urandom);
      y = AW'($urandom);
      if ($urandom_range(3) == 0) begin
        r = AW'($urandom_range(25736)) - 16'sd12868;
        p = ($urandom_range(1)) ? 16'sd12868 : -16'sd12868;
      end
      rotation_matrix(r, p, y, mx);
      pending_matrices.push_back(mx);
      send_angles(r, p, y);
    end
    in_valid_i <= 1'b0;
    quiet_phase = 1'b0;
    while (pending_matrices.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    if (errors == 0) begin
      $display("euler_zyx_to_rotation_matrix regression: pass");
    end else begin
      $display("euler_zyx_to_rotation_matrix regression: fail");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("euler_zyx_to_rotation_matrix regression: fail");
      $finish;
    end
    out_stall_i <= rst_ni && idle_now();
  end

  always @(posedge clk_i) begin
    logic signed [OW-1:0] got [9];
    matrix_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o};
      if (pending_matrices.size() == 0) begin
        $error("unexpected output transaction");
        errors++;
      end else begin
        want = pending_matrices.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== want.m[i]) begin
            $error("%s: expected %0d, got %0d", field_names[i], want.m[i], got[i]);
            errors++;
          end
        end
      end
    end
  end
endmodule

// ===== filelist.f =====
rtl/ezr_pkg.sv
rtl/ezr_cordic_lane.sv
rtl/ezr_merge.sv
rtl/euler_zyx_to_rotation_matrix.sv
tb/euler_zyx_to_rotation_matrix_test.sv
